FILE: rtl/core/urlqd_pkg.sv
// Shared types, codes and character helpers for the URL query percent decoder.
package urlqd_pkg;

  typedef enum logic [2:0] {
    PH_PATH       = 3'd0,
    PH_PATH_DONE  = 3'd1,
    PH_PARAM_DONE = 3'd2,
    PH_NAME       = 3'd3,
    PH_VALUE      = 3'd4
  } phase_t;

  localparam logic [1:0] DEST_PATH  = 2'd0;
  localparam logic [1:0] DEST_NAME  = 2'd1;
  localparam logic [1:0] DEST_VALUE = 2'd2;

  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_FIRST = 2'd1;
  localparam logic [1:0] ESC_LAST  = 2'd2;

  localparam logic [7:0] CHR_QUERY   = 8'h3f;
  localparam logic [7:0] CHR_AMP     = 8'h26;
  localparam logic [7:0] CHR_EQUALS  = 8'h3d;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2b;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_NUL     = 8'h00;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_char;
    logic       param_present;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic [1:0] destination;
    logic [2:0] parser_state;
  } out_item_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/url_query_percent_decoder.sv
// Top level of the URL query percent decoder with its two-entry result buffer.
//
// The decoder takes one URL byte or an end mark per item and returns exactly one result per
// item, one item per clock when the output side keeps up. The parse phase, the escape digit
// count and the partial escape value are updated in the cycle the item is accepted, and the
// result is registered in an output register. A second result register catches a result
// while the first is stalled, so in_stall rises only once both hold an item; it is a register
// and so does not follow out_stall in the same cycle.
module url_query_percent_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  urlqd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output urlqd_pkg::out_item_t out_data
);

  urlqd_pkg::phase_t    phase_r, phase_nxt;
  logic [1:0]           esc_cnt_r, esc_cnt_nxt;
  logic [7:0]           esc_val_r, esc_val_nxt;
  urlqd_pkg::out_item_t res;
  urlqd_pkg::out_item_t out_r, skid_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 accept, out_take, out_free;
  logic                 valid;
  logic [7:0]           ch;
  logic [1:0]           dest;
  logic [3:0]           digit;
  logic [7:0]           esc_byte;
  logic [7:0]           c;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = out_take || !out_valid_r;

  assign c        = in_data.in_char;
  assign digit    = urlqd_pkg::hex_digit(c);
  assign esc_byte = {esc_val_r[3:0], digit};

  always_comb begin
    phase_nxt   = phase_r;
    esc_cnt_nxt = esc_cnt_r;
    esc_val_nxt = esc_val_r;
    valid       = 1'b0;
    ch          = 8'd0;
    dest        = urlqd_pkg::DEST_PATH;
    if (in_data.operation) begin
      unique case (phase_r)
        urlqd_pkg::PH_PATH: phase_nxt = urlqd_pkg::PH_PATH_DONE;
        urlqd_pkg::PH_NAME, urlqd_pkg::PH_VALUE: phase_nxt = urlqd_pkg::PH_PARAM_DONE;
        default: ;
      endcase
    end else if (c != urlqd_pkg::CHR_NUL) begin
      unique case (phase_r)
        urlqd_pkg::PH_PATH: begin
          if (c == urlqd_pkg::CHR_QUERY) begin
            phase_nxt = urlqd_pkg::PH_PATH_DONE;
          end else begin
            valid = 1'b1;
            ch    = urlqd_pkg::lower_ascii(c);
          end
        end
        urlqd_pkg::PH_PATH_DONE, urlqd_pkg::PH_PARAM_DONE, urlqd_pkg::PH_NAME,
        urlqd_pkg::PH_VALUE: begin
          if (c == urlqd_pkg::CHR_AMP) begin
            phase_nxt   = urlqd_pkg::PH_PARAM_DONE;
            esc_cnt_nxt = urlqd_pkg::ESC_IDLE;
          end else if (c == urlqd_pkg::CHR_EQUALS && phase_r != urlqd_pkg::PH_VALUE) begin
            phase_nxt   = urlqd_pkg::PH_VALUE;
            esc_cnt_nxt = urlqd_pkg::ESC_IDLE;
          end else if (c == urlqd_pkg::CHR_PERCENT) begin
            esc_cnt_nxt = urlqd_pkg::ESC_FIRST;
            esc_val_nxt = 8'd0;
          end else if (in_data.param_present) begin
            if (esc_cnt_r != urlqd_pkg::ESC_IDLE) begin
              esc_val_nxt = esc_byte;
              if (esc_cnt_r == urlqd_pkg::ESC_LAST) begin
                esc_cnt_nxt = urlqd_pkg::ESC_IDLE;
                valid       = 1'b1;
                ch          = esc_byte;
              end else begin
                esc_cnt_nxt = esc_cnt_r + 2'd1;
              end
            end else begin
              valid = 1'b1;
              if (c == urlqd_pkg::CHR_PLUS) begin
                ch = urlqd_pkg::CHR_SPACE;
              end else if (phase_r == urlqd_pkg::PH_VALUE) begin
                ch = c;
              end else begin
                ch = urlqd_pkg::lower_ascii(c);
              end
            end
            if (phase_r == urlqd_pkg::PH_VALUE) begin
              dest = urlqd_pkg::DEST_VALUE;
            end else begin
              dest      = urlqd_pkg::DEST_NAME;
              phase_nxt = urlqd_pkg::PH_NAME;
            end
          end
        end
        default: ;
      endcase
    end
    res.char_valid   = valid;
    res.out_char     = valid ? ch : 8'd0;
    res.destination  = valid ? dest : urlqd_pkg::DEST_PATH;
    res.parser_state = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= urlqd_pkg::PH_PATH;
      esc_cnt_r    <= urlqd_pkg::ESC_IDLE;
      esc_val_r    <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        esc_cnt_r <= esc_cnt_nxt;
        esc_val_r <= esc_val_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (accept) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (accept) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Second result register holds an item while the first is empty.");

  a_esc_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    esc_cnt_r != 2'd3)
    else $error("Escape digit count has reached an impossible value.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("An accepted item left no result in the output register.");

  a_idle_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.char_valid) |->
      (out_r.out_char == 8'd0 && out_r.destination == urlqd_pkg::DEST_PATH))
    else $error("A result without a byte carries a byte or a destination.");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && skid_valid_r) |=> (skid_valid_r && $stable(skid_r)))
    else $error("The buffered result changed while both registers were full.");

endmodule
